// ===== hdl/rgmf_pkg.sv =====
// Shared types and constants for the replay-guarded message filter.
package rgmf_pkg;

    localparam logic [7:0]  MAGIC_VALUE    = 8'hAA;
    localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;
    localparam logic [2:0]  BEACON_LEN     = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_NOT_MINE  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN   = 2'd3;

    localparam logic [2:0] V_VALID       = 3'd0;
    localparam logic [2:0] V_STALE_RESET = 3'd1;
    localparam logic [2:0] V_STALE_MSG   = 3'd2;
    localparam logic [2:0] V_ADDED       = 3'd3;
    localparam logic [2:0] V_FULL        = 3'd4;

    localparam int          CFG_INDEX_W     = 8;
    localparam int          CFG_DATA_W      = 16;
    localparam logic [7:0]  REG_OWN_ADDRESS = 8'd0;
    localparam logic [7:0]  REG_BEACON_TYPE = 8'd1;

    // Classified header handed from front to back.
    typedef struct packed {
        logic [1:0]  status;
        logic        check;
        logic        beacon;
        logic [15:0] src;
        logic [15:0] rst;
        logic [15:0] msg;
        logic [7:0]  kind;
        logic [31:0] payload;
    } rec_t;

    // One table entry.
    typedef struct packed {
        logic [15:0] src;
        logic [15:0] rst;
        logic [15:0] msg;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        counter_checked;
        logic [2:0]  counter_verdict;
        logic [15:0] sender;
        logic [7:0]  kind;
        logic [2:0]  payload_length;
        logic [31:0] payload_out;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } back_state_t;

endpackage

// ===== hdl/replay_guarded_message_filter_top.sv =====
// Top level of the replay-guarded message filter.
// Flow: the front end classifies each header as it is taken into the middle queue; the back
// end pops one, searches the table if it is to be checked, and pushes its result word.
// The back end handles one header at a time, one table read a cycle while it searches,
// and waits in its emit state while the result queue is full.
// Reset (rst_n, async): empties both queues, clears source count and config registers.
module replay_guarded_message_filter_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         magic,
    input  logic [15:0]                        source_address,
    input  logic [15:0]                        destination_address,
    input  logic [15:0]                        sender_reset_count,
    input  logic [15:0]                        sender_message_count,
    input  logic [7:0]                         message_type,
    input  logic [31:0]                        payload_word,
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         status,
    output logic                               counter_checked,
    output logic [2:0]                         counter_verdict,
    output logic [15:0]                        sender,
    output logic [7:0]                         kind,
    output logic [2:0]                         payload_length,
    output logic [31:0]                        payload_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rgmf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rgmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import rgmf_pkg::*;

    logic [15:0] own_address_reg;
    logic [7:0]  beacon_type_reg;
    logic        cfg_write;

    logic        mid_push, mid_pop, mid_full, mid_empty;
    rec_t        mid_wr, mid_rd;
    logic        res_push, res_full;
    result_t     res_wr, res_rd;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            beacon_type_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_OWN_ADDRESS)
            begin
                own_address_reg <= cfg_data;
            end
            else if (cfg_index == REG_BEACON_TYPE)
            begin
                beacon_type_reg <= cfg_data[7:0];
            end
        end
    end

    rgmf_front u_front (
        .push                 (push),
        .full                 (full),
        .magic                (magic),
        .source_address       (source_address),
        .destination_address  (destination_address),
        .sender_reset_count   (sender_reset_count),
        .sender_message_count (sender_message_count),
        .message_type         (message_type),
        .payload_word         (payload_word),
        .own_address          (own_address_reg),
        .beacon_type_code     (beacon_type_reg),
        .q_full               (mid_full),
        .q_push               (mid_push),
        .q_data               (mid_wr)
    );

    rgmf_fifo #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (2)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_wr),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_rd),
        .empty   (mid_empty)
    );

    rgmf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (mid_empty),
        .q_data   (mid_rd),
        .q_pop    (mid_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_wr)
    );

    rgmf_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign status          = res_rd.status;
    assign counter_checked = res_rd.counter_checked;
    assign counter_verdict = res_rd.counter_verdict;
    assign sender          = res_rd.sender;
    assign kind            = res_rd.kind;
    assign payload_length  = res_rd.payload_length;
    assign payload_out     = res_rd.payload_out;

endmodule

// ===== hdl/rgmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rgmf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/rgmf_fifo.sv =====
// Small register queue used between front and back and on the result side.
module rgmf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_COUNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT   = AW'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == DEPTH_COUNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/rgmf_front.sv =====
// Front end: accepts headers, checks magic, destination and type.
module rgmf_front (
    input  logic               push,
    output logic               full,
    input  logic [7:0]         magic,
    input  logic [15:0]        source_address,
    input  logic [15:0]        destination_address,
    input  logic [15:0]        sender_reset_count,
    input  logic [15:0]        sender_message_count,
    input  logic [7:0]         message_type,
    input  logic [31:0]        payload_word,
    input  logic [15:0]        own_address,
    input  logic [7:0]         beacon_type_code,
    input  logic               q_full,
    output logic               q_push,
    output rgmf_pkg::rec_t     q_data
);

    import rgmf_pkg::*;

    logic bad_magic;
    logic for_me;
    logic is_beacon;

    assign bad_magic = (magic != MAGIC_VALUE);
    assign for_me    = (destination_address == own_address) ||
                       (destination_address == BROADCAST_ADDR);
    assign is_beacon = (message_type == beacon_type_code);

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        q_data.src     = source_address;
        q_data.rst     = sender_reset_count;
        q_data.msg     = sender_message_count;
        q_data.kind    = message_type;
        q_data.payload = payload_word;
        q_data.check   = 1'b0;
        q_data.beacon  = 1'b0;
        if (bad_magic)
        begin
            // drop echoes on bad magic
            q_data.status = ST_BAD_MAGIC;
            q_data.src    = '0;
            q_data.kind   = '0;
        end
        else if (!for_me)
        begin
            q_data.status = ST_NOT_MINE;
        end
        else
        begin
            q_data.check  = 1'b1;
            q_data.beacon = is_beacon;
            q_data.status = is_beacon ? ST_OK : ST_UNKNOWN;
        end
    end

endmodule

// ===== hdl/rgmf_back.sv =====
// Back end: scans the per-source counter table and builds each result word.
module rgmf_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  rgmf_pkg::rec_t      q_data,
    output logic                q_pop,
    input  logic                res_full,
    output logic                res_push,
    output rgmf_pkg::result_t   res_data
);

    import rgmf_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    back_state_t  state_reg, state_next;
    rec_t         work_reg, work_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] count_reg, count_next;
    logic         pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [2:0]   verdict_reg, verdict_next;

    logic         rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    entry_t       rd_data, wr_data;
    logic         hit, issue, search_done;

    rgmf_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A read issued last cycle is compared now while the next one goes out.
    assign hit         = pend_reg && (rd_data.src == work_reg.src);
    assign issue       = !hit && (scan_reg < count_reg);
    assign search_done = hit || (!issue && !pend_reg);
    assign rd_addr     = scan_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_data.check ? S_SEARCH : S_EMIT;
                end
            end
            S_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop         = 1'b0;
        res_push      = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg;
        wr_data.src   = work_reg.src;
        wr_data.rst   = work_reg.rst;
        wr_data.msg   = work_reg.msg;
        work_next     = work_reg;
        scan_next     = scan_reg;
        count_next    = count_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        verdict_next  = verdict_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    work_next    = q_data;
                    scan_next    = '0;
                    verdict_next = V_VALID;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    if (rd_data.rst < work_reg.rst)
                    begin
                        // newer boot: restart the sequence
                        wr_en        = 1'b1;
                        verdict_next = V_VALID;
                    end
                    else if (rd_data.rst != work_reg.rst)
                    begin
                        verdict_next = V_STALE_RESET;
                    end
                    else if (rd_data.msg < work_reg.msg)
                    begin
                        wr_en        = 1'b1;
                        verdict_next = V_VALID;
                    end
                    else
                    begin
                        verdict_next = V_STALE_MSG;
                    end
                end
                else if (issue)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[AW-1:0];
                    scan_next     = scan_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    // source not known: append if there is room
                    if (count_reg < FULL_COUNT)
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = count_reg[AW-1:0];
                        count_next   = count_reg + CW'(1);
                        verdict_next = V_ADDED;
                    end
                    else
                    begin
                        verdict_next = V_FULL;
                    end
                end
            end
            S_EMIT:
            begin
                res_push = !res_full;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_data.status          = work_reg.status;
        res_data.counter_checked = work_reg.check;
        res_data.counter_verdict = work_reg.check ? verdict_reg : V_VALID;
        res_data.sender          = work_reg.src;
        res_data.kind            = work_reg.kind;
        res_data.payload_length  = work_reg.beacon ? BEACON_LEN : 3'd0;
        res_data.payload_out     = work_reg.beacon ? work_reg.payload : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        verdict_reg  <= verdict_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("source count beyond table size");

    a_pend_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == S_SEARCH)
        else $error("table read outstanding outside search");

    a_count_means_added: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next != count_reg) |=> (verdict_reg == V_ADDED && state_reg == S_EMIT))
        else $error("table grew without an added verdict");

    a_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SEARCH && search_done))
        else $error("table write outside end of search");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the replay-guarded message filter top level.
module testbench;
    import rgmf_pkg::*;

    localparam int TABLE_N  = 16;
    localparam int POOL_N   = 24;
    localparam int RAND_N   = 170;
    localparam int HOLD_N   = 1500;
    localparam int WATCHDOG = 4000;
    localparam int DRAIN_N  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = 8'hFF;

    typedef struct packed {
        logic [7:0]  magic;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] rst;
        logic [15:0] msg;
        logic [7:0]  typ;
        logic [31:0] pay;
    } hdr_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [1:0]             status;
    logic                   counter_checked;
    logic [2:0]             counter_verdict;
    logic [15:0]            sender;
    logic [7:0]             kind;
    logic [2:0]             payload_length;
    logic [31:0]            payload_out;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    hdr_t                   hdr_cur = '0;

    // Predictor state: registers and the per-source counter table.
    logic [15:0] own_addr_m = 16'h0000;
    logic [7:0]  beacon_code_m = 8'h00;
    logic [15:0] tbl_src [TABLE_N];
    logic [15:0] tbl_rst [TABLE_N];
    logic [15:0] tbl_msg [TABLE_N];
    int          tbl_used = 0;

    hdr_t    header_backlog [$];
    result_t predicted_results [$];

    // Stimulus shaping: source pool and the sequence state each source is at.
    logic [15:0] pool_addr [POOL_N];
    int          seq_rst [POOL_N];
    int          seq_msg [POOL_N];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_armed = 1'b0;
    int hold_left = 0;
    bit hdr_taken = 1'b0;
    int quiet_cycles = 0;
    int errors = 0;
    int headers_in = 0;
    int results_out = 0;
    int status_seen [4] = '{default: 0};
    int verdict_seen [5] = '{default: 0};

    replay_guarded_message_filter_top #(.TABLE_ENTRIES(TABLE_N)) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .push                 (push),
        .full                 (full),
        .magic                (hdr_cur.magic),
        .source_address       (hdr_cur.src),
        .destination_address  (hdr_cur.dst),
        .sender_reset_count   (hdr_cur.rst),
        .sender_message_count (hdr_cur.msg),
        .message_type         (hdr_cur.typ),
        .payload_word         (hdr_cur.pay),
        .empty                (empty),
        .pop                  (pop),
        .status               (status),
        .counter_checked      (counter_checked),
        .counter_verdict      (counter_verdict),
        .sender               (sender),
        .kind                 (kind),
        .payload_length       (payload_length),
        .payload_out          (payload_out),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic result_t filter_header(hdr_t h);
        result_t r;
        bit      hit;
        r = '0;
        hit = 1'b0;
        if (h.magic != MAGIC_VALUE)
        begin
            r.status = ST_BAD_MAGIC;
            return r;
        end
        r.sender = h.src;
        r.kind = h.typ;
        if (h.dst != own_addr_m && h.dst != BROADCAST_ADDR)
        begin
            r.status = ST_NOT_MINE;
            return r;
        end
        r.counter_checked = 1'b1;
        for (int i = 0; i < tbl_used; i++)
        begin
            if (!hit && tbl_src[i] == h.src)
            begin
                hit = 1'b1;
                if (tbl_rst[i] < h.rst)
                begin
                    // newer boot restarts the sequence
                    tbl_rst[i] = h.rst;
                    tbl_msg[i] = h.msg;
                    r.counter_verdict = V_VALID;
                end
                else if (tbl_rst[i] != h.rst)
                    r.counter_verdict = V_STALE_RESET;
                else if (tbl_msg[i] < h.msg)
                begin
                    tbl_msg[i] = h.msg;
                    r.counter_verdict = V_VALID;
                end
                else
                    r.counter_verdict = V_STALE_MSG;
            end
        end
        if (!hit)
        begin
            if (tbl_used < TABLE_N)
            begin
                tbl_src[tbl_used] = h.src;
                tbl_rst[tbl_used] = h.rst;
                tbl_msg[tbl_used] = h.msg;
                tbl_used++;
                r.counter_verdict = V_ADDED;
            end
            else
                r.counter_verdict = V_FULL;
        end
        if (h.typ == beacon_code_m)
        begin
            r.status = ST_OK;
            r.payload_length = BEACON_LEN;
            r.payload_out = h.pay;
        end
        else
            r.status = ST_UNKNOWN;
        return r;
    endfunction

    // Mostly well-formed traffic from the source pool, the rest noise.
    function automatic hdr_t random_header();
        hdr_t h;
        int   p;
        int   act;
        int   m;
        h.pay = $urandom;
        if ($urandom_range(99) < 20)
        begin
            h.magic = ($urandom_range(1) == 1) ? MAGIC_VALUE : 8'($urandom_range(255));
            h.src = 16'($urandom_range(16'hFFFF));
            h.dst = 16'($urandom_range(16'hFFFF));
            h.rst = 16'($urandom_range(16'hFFFF));
            h.msg = 16'($urandom_range(16'hFFFF));
            h.typ = 8'($urandom_range(255));
            return h;
        end
        h.magic = ($urandom_range(99) < 92) ? MAGIC_VALUE : 8'($urandom_range(255));
        act = $urandom_range(99);
        if (act < 45)
            h.dst = own_addr_m;
        else if (act < 90)
            h.dst = BROADCAST_ADDR;
        else
            h.dst = 16'($urandom_range(16'hFFFF));
        h.typ = ($urandom_range(99) < 80) ? beacon_code_m : 8'($urandom_range(255));
        if ($urandom_range(99) < 85)
            p = $urandom_range(TABLE_N - 1);
        else
            p = $urandom_range(POOL_N - 1, TABLE_N);
        h.src = pool_addr[p];
        act = $urandom_range(99);
        if (act < 60)
        begin
            m = seq_msg[p] + $urandom_range(1, 300);
            if (m > 16'hFFFF)
            begin
                if (seq_rst[p] < 16'hFFFF)
                    seq_rst[p]++;
                m = $urandom_range(1000);
            end
            seq_msg[p] = m;
        end
        else if (act < 72)
        begin
            seq_rst[p] = seq_rst[p] + $urandom_range(1, 3000);
            if (seq_rst[p] > 16'hFFFF)
                seq_rst[p] = 16'hFFFF;
            seq_msg[p] = $urandom_range(16'hFFFF);
        end
        h.rst = 16'(seq_rst[p]);
        h.msg = 16'(seq_msg[p]);
        // replay an old count, or an old boot, without moving the sequence
        if (act >= 72 && act < 86)
            h.msg = 16'(seq_msg[p] - $urandom_range(seq_msg[p]));
        else if (act >= 86)
        begin
            if (seq_rst[p] > 0)
                h.rst = 16'(seq_rst[p] - $urandom_range(1, seq_rst[p]));
            else
                h.msg = 16'(seq_msg[p] - $urandom_range(seq_msg[p]));
        end
        return h;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_OWN_ADDRESS)
            own_addr_m = val;
        else if (idx == REG_BEACON_TYPE)
            beacon_code_m = val[7:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (header_backlog.size() > 0 || push || predicted_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_N) @(posedge clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, bit hold);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        hold_armed = hold;
        repeat (RAND_N) header_backlog.push_back(random_header());
        wait_drained();
    endtask

    // Sender: offer the next header word, hold it until taken.
    always @(negedge clk)
    begin : header_driver
        hdr_t nxt;
        if (rst_n && (!push || hdr_taken))
        begin
            if (header_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = header_backlog.pop_front();
                hdr_cur <= nxt;
                push <= 1'b1;
            end
            else
                push <= 1'b0;
        end
        hdr_taken = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off when armed.
    always @(negedge clk)
    begin : result_receiver
        if (hold_armed)
        begin
            hold_left = HOLD_N;
            hold_armed = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && pop && !empty)
        begin
            results_out++;
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected result word, got status %0d sender %h",
                         $time, status, sender);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("counter_checked", 32'(want.counter_checked),
                            32'(counter_checked));
                check_field("counter_verdict", 32'(want.counter_verdict),
                            32'(counter_verdict));
                check_field("sender", 32'(want.sender), 32'(sender));
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("payload_length", 32'(want.payload_length),
                            32'(payload_length));
                check_field("payload_out", want.payload_out, payload_out);
            end
        end
        if (rst_n && push && !full)
        begin
            want = filter_header(hdr_cur);
            predicted_results.push_back(want);
            status_seen[want.status]++;
            if (want.counter_checked)
                verdict_seen[want.counter_verdict]++;
            headers_in++;
            hdr_taken = 1'b1;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("replay_guarded_message_filter_top regression: fail");
            $finish;
        end
    end

    initial
    begin : sequencer
        logic [15:0] a;
        bit          dup;
        pool_addr[0] = 16'h0000;
        pool_addr[1] = 16'hFFFF;
        for (int p = 2; p < POOL_N; p++)
        begin
            do
            begin
                a = 16'($urandom_range(16'hFFFF));
                dup = 1'b0;
                for (int q = 0; q < p; q++)
                    if (pool_addr[q] == a)
                        dup = 1'b1;
            end
            while (dup);
            pool_addr[p] = a;
            seq_rst[p] = $urandom_range(16'hFFFF);
            seq_msg[p] = $urandom_range(16'hFFFF);
        end
        seq_rst[0] = 1;
        seq_msg[0] = 0;
        seq_rst[1] = 16'hFFFE;
        seq_msg[1] = 16'hFFFF;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(REG_OWN_ADDRESS, 16'h1234);
        write_reg(REG_BEACON_TYPE, 16'h005A);
        write_reg(REG_UNUSED_LOW, 16'hFFFF);

        // Directed: bad magic, foreign destination, one source through every
        // verdict, then fill the table and overflow it.
        header_backlog.push_back(hdr_t'{8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                        8'h00, 32'h0000_0000});
        header_backlog.push_back(hdr_t'{8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        8'hFF, 32'hFFFF_FFFF});
        header_backlog.push_back(hdr_t'{MAGIC_VALUE, 16'h4321, 16'h1235, 16'h0005, 16'h0005,
                                        8'h5A, 32'h0000_0001});
        header_backlog.push_back(hdr_t'{MAGIC_VALUE, 16'h0000, 16'h1234, 16'h0000, 16'h0000,
                                        8'h5A, 32'h0000_0000});
        header_backlog.push_back(hdr_t'{MAGIC_VALUE, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001,
                                        8'h5A, 32'hFFFF_FFFF});
        header_backlog.push_back(hdr_t'{MAGIC_VALUE, 16'h0000, 16'h1234, 16'h0000, 16'h0001,
                                        8'hA5, 32'h1234_5678});
        header_backlog.push_back(hdr_t'{MAGIC_VALUE, 16'h0000, 16'h1234, 16'h0001, 16'h0000,
                                        8'h5A, 32'h8765_4321});
        header_backlog.push_back(hdr_t'{MAGIC_VALUE, 16'h0000, 16'h1234, 16'h0000, 16'h7FFF,
                                        8'h5A, 32'h5555_AAAA});
        header_backlog.push_back(hdr_t'{MAGIC_VALUE, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF,
                                        8'h5A, 32'hA5A5_A5A5});
        for (int p = 2; p < TABLE_N; p++)
            header_backlog.push_back(hdr_t'{MAGIC_VALUE, pool_addr[p],
                                            (p % 2 == 0) ? 16'h1234 : BROADCAST_ADDR,
                                            16'(seq_rst[p]), 16'(seq_msg[p]), 8'h5A,
                                            32'($urandom)});
        header_backlog.push_back(hdr_t'{MAGIC_VALUE, pool_addr[TABLE_N], BROADCAST_ADDR,
                                        16'h0000, 16'h0000, 8'h5A, 32'h0F0F_0F0F});
        wait_drained();

        write_reg(REG_OWN_ADDRESS, 16'h0000);
        write_reg(REG_BEACON_TYPE, 16'h00FF);
        run_phase(0, 0, 1'b1);

        write_reg(REG_OWN_ADDRESS, 16'hFFFE);
        write_reg(REG_BEACON_TYPE, 16'h0000);
        write_reg(REG_UNUSED_TOP, 16'($urandom));
        run_phase(60, 0, 1'b0);

        write_reg(REG_OWN_ADDRESS, 16'($urandom_range(16'hFFFE)));
        write_reg(REG_BEACON_TYPE, 16'($urandom));
        run_phase(0, 60, 1'b0);

        write_reg(REG_BEACON_TYPE, 16'($urandom));
        write_reg(REG_OWN_ADDRESS, 16'($urandom_range(16'hFFFE)));
        run_phase(35, 35, 1'b0);

        errors += predicted_results.size();
        $display("%0d headers in, %0d results out; ok/bad magic/foreign/unknown %0d/%0d/%0d/%0d",
                 headers_in, results_out, status_seen[ST_OK], status_seen[ST_BAD_MAGIC],
                 status_seen[ST_NOT_MINE], status_seen[ST_UNKNOWN]);
        $display("table verdicts valid/stale boot/stale count/added/full %0d/%0d/%0d/%0d/%0d",
                 verdict_seen[V_VALID], verdict_seen[V_STALE_RESET], verdict_seen[V_STALE_MSG],
                 verdict_seen[V_ADDED], verdict_seen[V_FULL]);
        if (errors == 0)
            $display("replay_guarded_message_filter_top regression: pass");
        else
            $display("replay_guarded_message_filter_top regression: fail");
        $finish;
    end

endmodule

// ===== replay_guarded_message_filter_top.f =====
hdl/rgmf_pkg.sv
hdl/rgmf_ram.sv
hdl/rgmf_fifo.sv
hdl/rgmf_front.sv
hdl/rgmf_back.sv
hdl/replay_guarded_message_filter_top.sv
test/testbench.sv
